>>> sv/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg - shared types and constants of the BMP stream encoder
// Word layouts, configuration struct, command queue entry, header formatter.
// ----------------------------------------------------------------------------
package bse_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	localparam int SIZE_W = 13;   // configured width / height
	localparam int CNT_W  = 12;   // column / row counters

	localparam logic [SIZE_W-1:0] MAX_WIDTH_C  = SIZE_W'(MAX_WIDTH);
	localparam logic [SIZE_W-1:0] MAX_HEIGHT_C = SIZE_W'(MAX_HEIGHT);

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	// command queue
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

	// header words
	localparam int HDR_IDX_W = 5;
	localparam logic [HDR_IDX_W-1:0] HDR_LAST_NARROW = 5'd13;
	localparam logic [HDR_IDX_W-1:0] HDR_LAST_WIDE   = 5'd17;
	localparam logic [31:0] HDR_LEN_NARROW = 32'd54;
	localparam logic [31:0] HDR_LEN_WIDE   = 32'd70;
	localparam logic [31:0] DIB_LEN_NARROW = 32'd40;
	localparam logic [31:0] DIB_LEN_WIDE   = 32'd56;
	localparam logic [7:0]  BPP_NARROW     = 8'd24;
	localparam logic [7:0]  BPP_WIDE       = 8'd32;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;

	typedef struct packed {
		logic       mode;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} in_item_t;

	typedef struct packed {
		logic [31:0] out_word;
		logic [2:0]  byte_count;
		logic        run_last;
		logic        frame_end;
	} out_item_t;

	typedef struct packed {
		logic              pixel_format;
		logic [SIZE_W-1:0] image_width;
		logic [SIZE_W-1:0] image_height;
	} cfg_t;

	typedef struct packed {
		logic       is_header;
		logic       wide;
		logic       frame_end;
		logic [2:0] n_bytes;
		logic [7:0] alpha;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} cmd_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
		input logic [SIZE_W-1:0] lim);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v == '0)
			r = SIZE_W'(1);
		else if (v > lim)
			r = lim;
		return r;
	endfunction

	// One 32-bit word of the file header, byte 0 in the low bits.
	function automatic logic [31:0] header_word(input logic [HDR_IDX_W-1:0] idx,
		input logic wide, input logic [31:0] fsz, input logic [SIZE_W-1:0] w,
		input logic [SIZE_W-1:0] ht, input logic [31:0] psz);
		logic [31:0] hlen;
		logic [31:0] dib;
		logic [7:0]  bpp;
		logic [31:0] r;
		hlen = wide ? HDR_LEN_WIDE : HDR_LEN_NARROW;
		dib  = wide ? DIB_LEN_WIDE : DIB_LEN_NARROW;
		bpp  = wide ? BPP_WIDE : BPP_NARROW;
		unique case (idx)
			5'd0:    r = {fsz[15:0], 8'd77, 8'd66};
			5'd1:    r = {16'd0, fsz[31:16]};
			5'd2:    r = {hlen[15:0], 16'd0};
			5'd3:    r = {dib[15:0], hlen[31:16]};
			5'd4:    r = {(16)'(w), dib[31:16]};
			5'd5:    r = {(16)'(ht), 16'd0};
			5'd6:    r = {8'd0, 8'd1, 16'd0};
			5'd7:    r = {24'd0, bpp};
			5'd8:    r = {psz[15:0], 16'd0};
			5'd9:    r = {8'd46, 8'd35, psz[31:16]};
			5'd10:   r = {8'd46, 8'd35, 16'd0};
			5'd14:   r = 32'hFF00_00FF;   // red mask high + green mask low
			5'd15:   r = 32'h00FF_0000;
			5'd17:   r = 32'h0000_FF00;   // alpha mask high bytes
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

>>> sv/bmp_stream_encoder_unit.sv
// ----------------------------------------------------------------------------
// bmp_stream_encoder_unit - BMP file byte stream from a pixel stream
// Start items emit the 24-bit or 32-bit file header, pixel items emit their
// BGR(A) bytes plus row padding, packed into words of up to four bytes.
// ----------------------------------------------------------------------------
//
//  channel   | handshake            | payload
//  ----------+----------------------+--------------------------------------
//  input     | push / full          | in_item  (mode, red, green, blue, alpha)
//  result    | empty / pop          | out_item (out_word, byte_count,
//            |                      |           run_last, frame_end)
//  config    | wr_en (no wait)      | wr_index, wr_data
//
//  Words: a pixel makes one word (two at a 24-bit row end with 2 or 3 pad
//  bytes); the back end turns out one word per cycle while the output is
//  not stalled, so pixels run at one per cycle outside two-word row ends. A
//  start item makes 14 header words (24-bit) or 18 (32-bit). The first word
//  goes through the command queue and the command register to the output.
//  Reset clears counters, queue pointers and the output valid flag; there is
//  no clearing pass. A 4-entry command queue lets input run ahead while
//  the output is stalled; full rises only when that queue fills.
// ----------------------------------------------------------------------------
module bmp_stream_encoder_unit import bse_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// input word channel
	input  logic                  push,
	output logic                  full,
	input  in_item_t              in_item,
	// result word channel
	output logic                  empty,
	input  logic                  pop,
	output out_item_t             out_item,
	// configuration writes
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	cfg_t cfg_q;
	logic q_full;
	logic q_empty;
	logic q_wr;
	logic q_rd;
	cmd_t q_wr_data;
	cmd_t q_rd_data;

	// Configuration registers; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_format <= 1'b0;
			cfg_q.image_width  <= SIZE_W'(1);
			cfg_q.image_height <= SIZE_W'(1);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PIXEL_FORMAT: cfg_q.pixel_format <= wr_data[0];
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= wr_data[SIZE_W-1:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= wr_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Front: position tracking and command build.
	bse_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.in_item (in_item),
		.full    (full),
		.cfg     (cfg_q),
		.q_full  (q_full),
		.q_wr    (q_wr),
		.q_data  (q_wr_data)
	);

	// Decoupling queue.
	bse_cmd_fifo u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wr_data),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_data (q_rd_data),
		.empty   (q_empty)
	);

	// Back: word expansion and output register.
	bse_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_data   (q_rd_data),
		.q_rd     (q_rd),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item)
	);

endmodule

>>> sv/bse_front.sv
// ----------------------------------------------------------------------------
// bse_front - input side of the BMP stream encoder
// Accepts items, tracks column/row position, classifies each item into a
// command for the back end.
// ----------------------------------------------------------------------------
module bse_front import bse_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_item_t in_item,
	output logic     full,
	input  cfg_t     cfg,
	input  logic     q_full,
	output logic     q_wr,
	output cmd_t     q_data
);

	logic [CNT_W-1:0]  column_count_q;
	logic [CNT_W-1:0]  row_count_q;
	logic [SIZE_W-1:0] w;
	logic [SIZE_W-1:0] ht;
	logic              row_end;
	logic              frame_last;
	logic [1:0]        pad;

	assign full = q_full;
	assign q_wr = push & ~q_full;

	assign w          = clamp_size(cfg.image_width, MAX_WIDTH_C);
	assign ht         = clamp_size(cfg.image_height, MAX_HEIGHT_C);
	assign row_end    = SIZE_W'(column_count_q) >= (w - SIZE_W'(1));
	assign frame_last = SIZE_W'(row_count_q) >= (ht - SIZE_W'(1));
	assign pad        = w[1:0];   // (4 - 3w mod 4) mod 4 == w mod 4

	always_comb begin
		q_data.is_header = (in_item.mode == MODE_START);
		q_data.wide      = cfg.pixel_format;
		q_data.frame_end = (in_item.mode == MODE_PIXEL) & row_end & frame_last;
		q_data.alpha     = in_item.alpha;
		q_data.red       = in_item.red;
		q_data.green     = in_item.green;
		q_data.blue      = in_item.blue;
		if (cfg.pixel_format)
			q_data.n_bytes = 3'd4;
		else if (row_end)
			q_data.n_bytes = 3'd3 + 3'(pad);
		else
			q_data.n_bytes = 3'd3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (q_wr) begin
			if (in_item.mode == MODE_START) begin
				column_count_q <= '0;
				row_count_q    <= '0;
			end else if (row_end) begin
				column_count_q <= '0;
				row_count_q    <= frame_last ? '0 : row_count_q + CNT_W'(1);
			end else begin
				column_count_q <= column_count_q + CNT_W'(1);
			end
		end
	end

endmodule

>>> sv/bse_cmd_fifo.sv
// ----------------------------------------------------------------------------
// bse_cmd_fifo - command queue between front and back end
// Small register FIFO of classified commands.
// ----------------------------------------------------------------------------
module bse_cmd_fifo import bse_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic empty
);

	cmd_t                  mem_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_PTR_W:0]   count_q;
	logic                  do_wr;
	logic                  do_rd;

	assign full    = (count_q == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + CMDQ_PTR_W'(1);
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + CMDQ_PTR_W'(1);
			if (do_wr & ~do_rd)
				count_q <= count_q + (CMDQ_PTR_W+1)'(1);
			else if (do_rd & ~do_wr)
				count_q <= count_q - (CMDQ_PTR_W+1)'(1);
		end
	end

endmodule

>>> sv/bse_back.sv
// ----------------------------------------------------------------------------
// bse_back - output side of the BMP stream encoder
// Expands commands into header or pixel words and holds the output register.
// ----------------------------------------------------------------------------
module bse_back import bse_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_empty,
	input  cmd_t      q_data,
	output logic      q_rd,
	output logic      empty,
	input  logic      pop,
	output out_item_t out_item
);

	cmd_t                 cur_q;
	logic                 cur_valid_q;
	logic [HDR_IDX_W-1:0] idx_q;
	logic                 out_valid_q;
	out_item_t            out_q;
	logic [27:0]          psz_q;

	logic [SIZE_W-1:0]    w;
	logic [SIZE_W-1:0]    ht;
	logic [14:0]          row_bytes;
	logic [31:0]          psz;
	logic [31:0]          fsz;
	logic [HDR_IDX_W-1:0] last_idx;
	logic                 is_last;
	logic                 slot_free;
	logic                 emit;
	out_item_t            nxt;

	// pixel array size is registered and follows the configuration in the next cycle
	assign w  = clamp_size(cfg.image_width, MAX_WIDTH_C);
	assign ht = clamp_size(cfg.image_height, MAX_HEIGHT_C);
	assign row_bytes = cfg.pixel_format ? {w, 2'b00}
		: ({1'b0, w, 1'b0} + 15'(w) + 15'(w[1:0]));

	always_ff @(posedge clk) begin
		psz_q <= 28'(row_bytes * ht);
	end

	assign psz = 32'(psz_q);
	assign fsz = psz + (cur_q.wide ? HDR_LEN_WIDE : HDR_LEN_NARROW);

	always_comb begin
		if (cur_q.is_header)
			last_idx = cur_q.wide ? HDR_LAST_WIDE : HDR_LAST_NARROW;
		else
			last_idx = (cur_q.n_bytes > 3'd4) ? HDR_IDX_W'(1) : '0;
	end

	assign is_last   = (idx_q == last_idx);
	assign slot_free = ~out_valid_q | pop;
	assign emit      = cur_valid_q & slot_free;
	assign q_rd      = ~q_empty & (~cur_valid_q | (emit & is_last));

	always_comb begin
		nxt.run_last  = is_last;
		nxt.frame_end = is_last & cur_q.frame_end;
		if (cur_q.is_header) begin
			nxt.out_word   = header_word(idx_q, cur_q.wide, fsz, w, ht, psz);
			nxt.byte_count = is_last ? 3'd2 : 3'd4;
		end else if (idx_q == '0) begin
			nxt.out_word   = {cur_q.wide ? cur_q.alpha : 8'd0,
				cur_q.red, cur_q.green, cur_q.blue};
			nxt.byte_count = (cur_q.n_bytes > 3'd4) ? 3'd4 : cur_q.n_bytes;
		end else begin
			nxt.out_word   = 32'd0;   // trailing row padding
			nxt.byte_count = cur_q.n_bytes - 3'd4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_rd) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (emit & is_last) begin
				cur_valid_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + HDR_IDX_W'(1);
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd)
			cur_q <= q_data;
		if (emit)
			out_q <= nxt;
	end

	assign empty    = ~out_valid_q;
	assign out_item = out_q;

endmodule

>>> tb/bmp_stream_encoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_stream_encoder_unit_tb - self-checking bench for the BMP stream encoder
// Drives start and pixel words through the push/full side, pops result words
// with random stalls and checks each one against a bit-exact predictor of the
// header and pixel byte stream. Sizes and format change between phases.
// ----------------------------------------------------------------------------

// Predicts the result words of every accepted input word and checks popped ones.
class bmp_scoreboard;
	bit                     wide_fmt;
	int unsigned            cfg_width;
	int unsigned            cfg_height;
	int unsigned            col_cnt;
	int unsigned            row_cnt;
	logic [7:0]             file_bytes [70];
	bse_pkg::out_item_t     expected_words [$];
	int                     errors;

	function new();
		wide_fmt   = 1'b0;
		cfg_width  = 1;
		cfg_height = 1;
		col_cnt    = 0;
		row_cnt    = 0;
		errors     = 0;
	endfunction

	function void write_reg(logic [bse_pkg::CFG_IDX_W-1:0] idx,
		logic [bse_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			bse_pkg::REG_PIXEL_FORMAT: wide_fmt   = data[0];
			bse_pkg::REG_IMAGE_WIDTH:  cfg_width  = 32'(data);
			bse_pkg::REG_IMAGE_HEIGHT: cfg_height = 32'(data);
			default: ;
		endcase
	endfunction

	function int unsigned clamp(int unsigned v, int unsigned lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return v;
	endfunction

	function void put_le32(int off, logic [31:0] v);
		for (int i = 0; i < 4; i++)
			file_bytes[off + i] = v[8*i +: 8];
	endfunction

	// pack n staged bytes into words of up to four, low byte first
	function void pack_bytes(int n, bit fend);
		int                 pos;
		int                 take;
		bse_pkg::out_item_t w;
		pos = 0;
		while (pos < n) begin
			take = (n - pos > 4) ? 4 : n - pos;
			w = '0;
			for (int i = 0; i < take; i++)
				w.out_word[8*i +: 8] = file_bytes[pos + i];
			pos += take;
			w.byte_count = 3'(take);
			w.run_last   = (pos >= n);
			w.frame_end  = (pos >= n) && fend;
			expected_words.push_back(w);
		end
	endfunction

	function void note_input(bse_pkg::in_item_t item);
		int unsigned w;
		int unsigned ht;
		int unsigned pad;
		int unsigned row_bytes;
		int unsigned hlen;
		int          n;
		logic [31:0] psz;
		logic [31:0] fsz;
		bit          row_end;
		bit          fend;
		w    = clamp(cfg_width, bse_pkg::MAX_WIDTH);
		ht   = clamp(cfg_height, bse_pkg::MAX_HEIGHT);
		pad  = wide_fmt ? 0 : (4 - (w * 3) % 4) % 4;
		fend = 1'b0;
		if (item.mode == bse_pkg::MODE_START) begin
			col_cnt   = 0;
			row_cnt   = 0;
			row_bytes = wide_fmt ? w * 4 : w * 3 + pad;
			hlen      = wide_fmt ? bse_pkg::HDR_LEN_WIDE : bse_pkg::HDR_LEN_NARROW;
			psz       = row_bytes * ht;
			fsz       = psz + hlen;
			foreach (file_bytes[i])
				file_bytes[i] = 8'd0;
			file_bytes[0] = 8'd66;
			file_bytes[1] = 8'd77;
			put_le32(2, fsz);
			put_le32(10, hlen);
			put_le32(14, wide_fmt ? bse_pkg::DIB_LEN_WIDE : bse_pkg::DIB_LEN_NARROW);
			put_le32(18, w);
			put_le32(22, ht);
			file_bytes[26] = 8'd1;
			file_bytes[28] = wide_fmt ? bse_pkg::BPP_WIDE : bse_pkg::BPP_NARROW;
			put_le32(34, psz);
			file_bytes[38] = 8'd35;
			file_bytes[39] = 8'd46;
			file_bytes[42] = 8'd35;
			file_bytes[43] = 8'd46;
			if (wide_fmt) begin
				// channel masks: red, green, blue, alpha
				file_bytes[56] = 8'hFF;
				file_bytes[59] = 8'hFF;
				file_bytes[62] = 8'hFF;
				file_bytes[69] = 8'hFF;
			end
			pack_bytes(hlen, 1'b0);
		end else begin
			row_end       = (col_cnt >= w - 1);
			file_bytes[0] = item.blue;
			file_bytes[1] = item.green;
			file_bytes[2] = item.red;
			n = 3;
			if (wide_fmt) begin
				file_bytes[3] = item.alpha;
				n = 4;
			end else if (row_end) begin
				for (int i = 0; i < pad; i++) begin
					file_bytes[n] = 8'd0;
					n++;
				end
			end
			if (row_end) begin
				col_cnt = 0;
				if (row_cnt >= ht - 1) begin
					row_cnt = 0;
					fend    = 1'b1;
				end else begin
					row_cnt++;
				end
			end else begin
				col_cnt++;
			end
			pack_bytes(n, fend);
		end
	endfunction

	function void check_result(bse_pkg::out_item_t got);
		bse_pkg::out_item_t exp;
		if (expected_words.size() == 0) begin
			$display("%0t: unexpected result word, actual %h", $time, got);
			errors++;
			return;
		end
		exp = expected_words.pop_front();
		if (got.out_word !== exp.out_word) begin
			$display("%0t: out_word expected %h actual %h", $time, exp.out_word, got.out_word);
			errors++;
		end
		if (got.byte_count !== exp.byte_count) begin
			$display("%0t: byte_count expected %0d actual %0d", $time,
				exp.byte_count, got.byte_count);
			errors++;
		end
		if (got.run_last !== exp.run_last) begin
			$display("%0t: run_last expected %b actual %b", $time, exp.run_last, got.run_last);
			errors++;
		end
		if (got.frame_end !== exp.frame_end) begin
			$display("%0t: frame_end expected %b actual %b", $time,
				exp.frame_end, got.frame_end);
			errors++;
		end
	endfunction

	function int outstanding();
		return expected_words.size();
	endfunction
endclass

module bmp_stream_encoder_unit_tb import bse_pkg::*; ();

	localparam logic FMT_BGR24  = 1'b0;
	localparam logic FMT_BGRA32 = 1'b1;

	// input word target of the run; from RUN_ITEMS - QUIET_ITEMS on, no idling on either side
	localparam int RUN_ITEMS   = 430;
	localparam int QUIET_ITEMS = 60;
	// cycles allowed after the last result before the block counts as idle
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 24;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	in_item_t              in_item;
	logic                  empty;
	logic                  pop;
	out_item_t             out_item;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	bmp_scoreboard sb;
	int            sent_count;
	bit            quiet;

	bmp_stream_encoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: the worst case is ~460 words x 18 result words with pop stalls,
	// and the timeout allows several times that.
	initial begin
		#10ms;
		$display("bmp_stream_encoder_unit_tb: FAIL");
		$finish;
	end

	function automatic in_item_t pixel_word(logic [7:0] r, logic [7:0] g, logic [7:0] b,
		logic [7:0] a);
		in_item_t it;
		it.mode  = MODE_PIXEL;
		it.red   = r;
		it.green = g;
		it.blue  = b;
		it.alpha = a;
		return it;
	endfunction

	function automatic in_item_t random_pixel();
		return pixel_word(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endfunction

	function automatic in_item_t start_word();
		in_item_t it;
		it      = random_pixel();
		it.mode = MODE_START;   // channels stay random, the block ignores them
		return it;
	endfunction

	// Offer one input word and hold it until the block takes it. Push is left
	// high so back-to-back words stream; an idle burst lowers it.
	task automatic send_word(in_item_t item);
		push    <= 1'b1;
		in_item <= item;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_input(item);
		sent_count++;
		quiet = (sent_count >= RUN_ITEMS - QUIET_ITEMS);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// Stop sending and let every expected word drain, plus a few cycles of
	// slack, so a register write cannot land under work in flight.
	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Caller guarantees idle. Enable drops for a cycle between writes.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(logic fmt, logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
		wait_idle();
		write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(fmt));
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
	endtask

	// single register change, used mid-frame (counters keep their values)
	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		wait_idle();
		write_reg(idx, data);
	endtask

	// Result side: pop with random stall bursts; every word taken is checked.
	// Outputs are read in the active region right after the edge, i.e. the
	// values the block presented at that edge.
	initial begin
		int stall_left;
		stall_left = 0;
		pop <= 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				sb.check_result(out_item);
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				pop <= 1'b0;
				stall_left = $urandom_range(1, 17) - 1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Stimulus: directed corner cases, then random frames, then drain and verdict.
	initial begin
		int          n_pix;
		int          w;
		int          h;
		bit          big;
		sb         = new();
		sent_count = 0;
		quiet      = 1'b0;
		arst_n   <= 1'b0;
		push     <= 1'b0;
		in_item  <= '0;
		wr_en    <= 1'b0;
		wr_index <= '0;
		wr_data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 24-bit 1x1, one pad byte, frame end on the only pixel
		send_word(start_word());
		send_word(pixel_word(8'hFF, 8'hFF, 8'hFF, 8'hFF));

		// 32-bit, width 0 read as 1, height above max read as max;
		// pixels with no new start keep counting
		configure(FMT_BGRA32, 13'd0, 13'd8191);
		send_word(start_word());
		send_word(pixel_word(8'h00, 8'h00, 8'h00, 8'h00));
		send_word(pixel_word(8'hFF, 8'h00, 8'hFF, 8'h00));

		// widest row, height 0 read as 1
		configure(FMT_BGR24, 13'd4096, 13'd0);
		send_word(start_word());
		send_word(pixel_word(8'h12, 8'h34, 8'h56, 8'h78));

		// width above max clamps
		configure(FMT_BGR24, 13'd8191, 13'd4096);
		send_word(start_word());

		// 2x2, two pad bytes per row; a start mid-frame clears the counters
		configure(FMT_BGR24, 13'd2, 13'd2);
		send_word(start_word());
		send_word(pixel_word(8'hFF, 8'h00, 8'hFF, 8'hAA));
		send_word(start_word());
		repeat (4) send_word(random_pixel());

		// three pad bytes, the row end spills into a second word
		configure(FMT_BGR24, 13'd3, 13'd1);
		send_word(start_word());
		repeat (3) send_word(random_pixel());

		// size and format changes mid-frame take effect at once
		configure(FMT_BGR24, 13'd4, 13'd2);
		send_word(start_word());
		repeat (3) send_word(random_pixel());
		set_reg(REG_IMAGE_WIDTH, 13'd2);      // column past new last index
		send_word(random_pixel());
		set_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_BGRA32));
		repeat (2) send_word(random_pixel());

		// Random frames: mostly small well-formed frames with random content;
		// some have no start, extra starts, spare pixels or a mid-frame change.
		// A few use full-range sizes and send only a handful of pixels.
		while (sent_count < RUN_ITEMS) begin
			big = ($urandom_range(0, 9) >= 8);
			if (big) begin
				w = $urandom_range(0, 8191);
				h = $urandom_range(0, 8191);
				n_pix = $urandom_range(1, 6);
			end else begin
				w = $urandom_range(1, 9);
				h = $urandom_range(1, 4);
				n_pix = w * h + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
			end
			configure(1'($urandom_range(0, 1)), CFG_DATA_W'(w), CFG_DATA_W'(h));
			if ($urandom_range(0, 9) != 0)
				send_word(start_word());
			for (int i = 0; i < n_pix; i++) begin
				if (!big && $urandom_range(0, 29) == 0)
					set_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(1, 9)));
				else if ($urandom_range(0, 29) == 0)
					set_reg(REG_PIXEL_FORMAT, CFG_DATA_W'($urandom_range(0, 1)));
				if ($urandom_range(0, 39) == 0)
					send_word(start_word());
				send_word(random_pixel());
			end
		end

		// drain, then a few more cycles to catch stray words
		push <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("bmp_stream_encoder_unit_tb: PASS");
		else
			$display("bmp_stream_encoder_unit_tb: FAIL");
		$finish;
	end

endmodule
